// ===== rtl/tood_pkg.sv =====
// Shared constants and types for the threshold on/off duty timer.
package tood_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int TIME_BITS   = 32;

  // Reset value of the level threshold (truncated to the sample width).
  localparam int THRESH_RESET = 512;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_THRESHOLD = '0;

  typedef struct packed {
    logic active;
    logic rise;
    logic fall;
  } tood_flags_t;

endpackage

// ===== rtl/tood_cfg.sv =====
// APB register block: holds the level threshold.
module tood_cfg #(
  parameter int SAMPLE_BITS = tood_pkg::SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tood_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [tood_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tood_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  output logic [SAMPLE_BITS-1:0]             level_threshold
);

  logic [tood_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic                              hit_thresh;

  assign reg_idx    = paddr[tood_pkg::APB_ADDR_BITS-1:2];
  assign hit_thresh = (reg_idx == tood_pkg::REG_LEVEL_THRESHOLD);
  assign pready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= SAMPLE_BITS'(tood_pkg::THRESH_RESET);
    end else if (psel && penable && pwrite && hit_thresh) begin
      level_threshold <= pwdata[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_thresh) begin
      prdata = tood_pkg::APB_DATA_BITS'(level_threshold);
    end
  end

endmodule

// ===== rtl/tood_core.sv =====
// Level detection and on/off period timing state, updated once per step.
module tood_core #(
  parameter int SAMPLE_BITS = tood_pkg::SAMPLE_BITS,
  parameter int TIME_BITS   = tood_pkg::TIME_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [SAMPLE_BITS-1:0]    sample,
  input  logic [TIME_BITS-1:0]      now_ms,
  input  logic [SAMPLE_BITS-1:0]    level_threshold,
  output tood_pkg::tood_flags_t     flags,
  output logic [SAMPLE_BITS-1:0]    last_sample,
  output logic [TIME_BITS-1:0]      on_elapsed,
  output logic [TIME_BITS-1:0]      off_elapsed,
  output logic [TIME_BITS-1:0]      on_prev,
  output logic [TIME_BITS-1:0]      off_prev,
  output logic [TIME_BITS-1:0]      on_count,
  output logic [TIME_BITS-1:0]      off_count
);

  logic                  level_reg;
  logic [TIME_BITS-1:0]  on_start_ms;
  logic [TIME_BITS-1:0]  off_start_ms;

  tood_pkg::tood_flags_t flags_next;
  logic [TIME_BITS-1:0]  on_elapsed_next;
  logic [TIME_BITS-1:0]  off_elapsed_next;
  logic [TIME_BITS-1:0]  on_prev_next;
  logic [TIME_BITS-1:0]  off_prev_next;
  logic [TIME_BITS-1:0]  on_count_next;
  logic [TIME_BITS-1:0]  off_count_next;
  logic [TIME_BITS-1:0]  on_start_ms_next;
  logic [TIME_BITS-1:0]  off_start_ms_next;

  always_comb begin
    flags_next.active = (sample < level_threshold);
    flags_next.rise   = flags_next.active && !level_reg;
    flags_next.fall   = !flags_next.active && level_reg;

    // Running time uses the old start, even on the edge step
    on_elapsed_next  = flags_next.active ? (now_ms - on_start_ms)
                     : (flags_next.fall ? '0 : on_elapsed);
    off_elapsed_next = !flags_next.active ? (now_ms - off_start_ms)
                     : (flags_next.rise ? '0 : off_elapsed);

    on_prev_next      = flags_next.fall ? on_elapsed : on_prev;
    off_prev_next     = flags_next.rise ? off_elapsed : off_prev;
    on_count_next     = flags_next.fall ? on_count + 1'b1 : on_count;
    off_count_next    = flags_next.rise ? off_count + 1'b1 : off_count;
    on_start_ms_next  = flags_next.rise ? now_ms : on_start_ms;
    off_start_ms_next = flags_next.fall ? now_ms : off_start_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_reg    <= 1'b0;
      flags        <= '0;
      last_sample  <= '0;
      on_start_ms  <= '0;
      off_start_ms <= '0;
      on_elapsed   <= '0;
      off_elapsed  <= '0;
      on_prev      <= '0;
      off_prev     <= '0;
      on_count     <= '0;
      off_count    <= '0;
    end else if (step) begin
      level_reg    <= flags_next.active;
      flags        <= flags_next;
      last_sample  <= sample;
      on_start_ms  <= on_start_ms_next;
      off_start_ms <= off_start_ms_next;
      on_elapsed   <= on_elapsed_next;
      off_elapsed  <= off_elapsed_next;
      on_prev      <= on_prev_next;
      off_prev     <= off_prev_next;
      on_count     <= on_count_next;
      off_count    <= off_count_next;
    end
  end

endmodule

// ===== rtl/threshold_on_off_duty_timer.sv =====
// Threshold on/off duty timer: input stage, timing core and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per sample: the
//   converter reading and its millisecond timestamp. Output channel
//   (out_valid/out_ready) returns one beat per input beat, in order, with
//   the level, edge flags, running and last on/off times and period counts.
//   level_threshold is written over the APB port at byte address 0; a
//   sample strictly below it counts as active.
//   An accepted beat moves from the input stage into the result register
//   once that is free or being drained. Throughput: one beat per cycle while
//   out_ready keeps up; each step does one compare, two subtractions, two increments.
//   A stalled output holds its beat; the input stage still takes one more
//   beat, then in_ready drops until the result is taken.
//   Synchronous reset clears all timing state and counters, sets the
//   threshold to its reset value and empties both stages.
module threshold_on_off_duty_timer #(
  parameter int SAMPLE_BITS = tood_pkg::SAMPLE_BITS,
  parameter int TIME_BITS   = tood_pkg::TIME_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tood_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [tood_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tood_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic [TIME_BITS-1:0]               now_ms,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [SAMPLE_BITS-1:0]             sample_seen,
  output logic                               level_active,
  output logic                               rising_edge,
  output logic                               falling_edge,
  output logic [TIME_BITS-1:0]               on_time_now,
  output logic [TIME_BITS-1:0]               off_time_now,
  output logic [TIME_BITS-1:0]               on_time_last,
  output logic [TIME_BITS-1:0]               off_time_last,
  output logic [TIME_BITS-1:0]               on_periods,
  output logic [TIME_BITS-1:0]               off_periods
);

  logic [SAMPLE_BITS-1:0] level_threshold;
  logic                   stage_valid;
  logic [SAMPLE_BITS-1:0] stage_sample;
  logic [TIME_BITS-1:0]   stage_now;
  logic                   step;
  tood_pkg::tood_flags_t  flags;

  tood_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .level_threshold(level_threshold)
  );

  // Advance the staged beat when the result register is free or being drained
  assign step     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_sample <= sample;
      stage_now    <= now_ms;
    end
  end

  tood_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .sample         (stage_sample),
    .now_ms         (stage_now),
    .level_threshold(level_threshold),
    .flags          (flags),
    .last_sample    (sample_seen),
    .on_elapsed     (on_time_now),
    .off_elapsed    (off_time_now),
    .on_prev        (on_time_last),
    .off_prev       (off_time_last),
    .on_count       (on_periods),
    .off_count      (off_periods)
  );

  assign level_active = flags.active;
  assign rising_edge  = flags.rise;
  assign falling_edge = flags.fall;

endmodule

// ===== tb/sv/tood_tb_pkg.sv =====
// Scoreboard for the threshold on/off duty timer: timing predictor and result check.
package tood_tb_pkg;
  import tood_pkg::*;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_seen;
    tood_flags_t            flags;
    logic [TIME_BITS-1:0]   on_time_now;
    logic [TIME_BITS-1:0]   off_time_now;
    logic [TIME_BITS-1:0]   on_time_last;
    logic [TIME_BITS-1:0]   off_time_last;
    logic [TIME_BITS-1:0]   on_periods;
    logic [TIME_BITS-1:0]   off_periods;
  } timer_report_t;

  class duty_timer_scoreboard;
    logic [SAMPLE_BITS-1:0] threshold;
    logic                   level;
    logic [TIME_BITS-1:0]   on_start, off_start;
    logic [TIME_BITS-1:0]   on_run, off_run;
    logic [TIME_BITS-1:0]   on_last, off_last;
    logic [TIME_BITS-1:0]   on_cnt, off_cnt;
    timer_report_t          expected_reports[$];
    int                     errors;
    int                     noted;

    function new();
      threshold = SAMPLE_BITS'(THRESH_RESET);
      level     = 1'b0;
      on_start  = '0;
      off_start = '0;
      on_run    = '0;
      off_run   = '0;
      on_last   = '0;
      off_last  = '0;
      on_cnt    = '0;
      off_cnt   = '0;
      errors    = 0;
      noted     = 0;
    endfunction

    function void set_threshold(logic [APB_DATA_BITS-1:0] value);
      threshold = value[SAMPLE_BITS-1:0];
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Advance the timing state by one accepted sample and queue the report it yields.
    function void note_sample(logic [SAMPLE_BITS-1:0] s, logic [TIME_BITS-1:0] t);
      tood_flags_t   f;
      timer_report_t r;
      f.active = s < threshold;
      f.rise   = f.active && !level;
      f.fall   = !f.active && level;
      // running time uses the old start, even on the step that moves it
      if (f.active) on_run = t - on_start;
      else off_run = t - off_start;
      if (f.rise) begin
        on_start = t;
        off_cnt  = off_cnt + 1'b1;
        off_last = off_run;
        off_run  = '0;
      end
      if (f.fall) begin
        off_start = t;
        on_cnt    = on_cnt + 1'b1;
        on_last   = on_run;
        on_run    = '0;
      end
      level           = f.active;
      r.sample_seen   = s;
      r.flags         = f;
      r.on_time_now   = on_run;
      r.off_time_now  = off_run;
      r.on_time_last  = on_last;
      r.off_time_last = off_last;
      r.on_periods    = on_cnt;
      r.off_periods   = off_cnt;
      expected_reports.push_back(r);
      noted++;
    endfunction

    function void compare_field(string name, logic [TIME_BITS-1:0] want,
                                logic [TIME_BITS-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(timer_report_t got);
      timer_report_t want;
      if (expected_reports.size() == 0) begin
        $error("result beat with no sample outstanding");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("sample_seen", TIME_BITS'(want.sample_seen), TIME_BITS'(got.sample_seen));
      compare_field("level_active", TIME_BITS'(want.flags.active), TIME_BITS'(got.flags.active));
      compare_field("rising_edge", TIME_BITS'(want.flags.rise), TIME_BITS'(got.flags.rise));
      compare_field("falling_edge", TIME_BITS'(want.flags.fall), TIME_BITS'(got.flags.fall));
      compare_field("on_time_now", want.on_time_now, got.on_time_now);
      compare_field("off_time_now", want.off_time_now, got.off_time_now);
      compare_field("on_time_last", want.on_time_last, got.on_time_last);
      compare_field("off_time_last", want.off_time_last, got.off_time_last);
      compare_field("on_periods", want.on_periods, got.on_periods);
      compare_field("off_periods", want.off_periods, got.off_periods);
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench for the threshold on/off duty timer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tood_pkg::*;
  import tood_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_OFF_AFTER = 600;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = REG_IDX_BITS'(1);

  typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_PATTERN} ready_mode_e;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SAMPLE_BITS-1:0]   sample = '0;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0]   sample_seen;
  logic                     level_active;
  logic                     rising_edge;
  logic                     falling_edge;
  logic [TIME_BITS-1:0]     on_time_now;
  logic [TIME_BITS-1:0]     off_time_now;
  logic [TIME_BITS-1:0]     on_time_last;
  logic [TIME_BITS-1:0]     off_time_last;
  logic [TIME_BITS-1:0]     on_periods;
  logic [TIME_BITS-1:0]     off_periods;

  duty_timer_scoreboard sb = new();

  logic [TIME_BITS-1:0] clock_ms = '0;
  bit                   want_active = 1'b0;
  int                   run_left = 0;
  int                   burst_left = 0;
  int                   gap_max = 0;

  always #6 clk = ~clk;

  threshold_on_off_duty_timer u_dut (.*);

  // Offer one sample beat; open a new burst, with a random gap, when the last one ran out.
  task automatic offer(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
    int n;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      n = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    sample   <= s;
    now_ms   <= t;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_sample(s, t);
  endtask

  // Drop valid and wait until every outstanding report is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [APB_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LEVEL_THRESHOLD) sb.set_threshold(data);
  endtask

  // Runs of samples on one side of the threshold, timestamps mostly advancing.
  task automatic run_phase(input int count);
    int                     thr;
    int                     pick;
    logic [SAMPLE_BITS-1:0] s;
    thr = int'(sb.threshold);
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        run_left    = $urandom_range(12, 1);
        want_active = !want_active;
      end
      run_left--;
      pick = $urandom_range(99, 0);
      if (pick < 10) s = SAMPLE_BITS'($urandom_range(1023, 0));
      else if (want_active && thr != 0)
        s = (pick < 25) ? SAMPLE_BITS'(thr - 1) : SAMPLE_BITS'($urandom_range(thr - 1, 0));
      else s = (pick < 25) ? SAMPLE_BITS'(thr) : SAMPLE_BITS'($urandom_range(1023, thr));
      pick = $urandom_range(99, 0);
      if (pick < 80) clock_ms = clock_ms + $urandom_range(40, 0);
      else if (pick < 90) clock_ms = clock_ms + $urandom_range(100000, 0);
      else if (pick < 95) clock_ms = clock_ms - $urandom_range(50, 0);
      else clock_ms = $urandom();
      offer(s, clock_ms);
    end
  endtask

  initial begin : stimulus
    int thr_plan[7];
    int gap_plan[7];
    thr_plan = '{512, 1023, 0, 1, 0, 0, 0};
    gap_plan = '{8, 0, 12, 4, 20, 6, 10};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: boundaries, edges, time going backwards and wrapping
    offer(10'd1023, 32'd0);
    offer(10'd0, 32'd100);
    offer(10'd511, 32'd150);
    offer(10'd512, 32'd300);
    offer(10'd700, 32'd200);
    offer(10'd5, 32'hFFFF_FFFF);
    offer(10'd1, 32'd5);
    offer(10'd513, 32'h8000_0000);
    offer(10'h2AA, 32'hAAAA_AAAA);
    offer(10'h155, 32'h5555_5555);
    offer(10'h3FF, 32'd0);
    drain();
    apb_write(REG_UNUSED, 32'h0000_0001);
    offer(10'd1, 32'd10);
    drain();
    // upper data bits must be dropped, leaving a zero threshold
    apb_write(REG_LEVEL_THRESHOLD, 32'hFFFF_FC00);
    offer(10'd0, 32'd20);
    offer(10'd1023, 32'd30);
    drain();
    apb_write(REG_LEVEL_THRESHOLD, 32'd1023);
    offer(10'd1022, 32'd40);
    offer(10'd1023, 32'd50);
    drain();
    apb_write(REG_LEVEL_THRESHOLD, 32'd1);
    offer(10'd0, 32'd60);
    offer(10'd1, 32'd70);

    for (int p = 0; p < 7; p++) begin
      drain();
      if (p >= 4) thr_plan[p] = $urandom_range(1023, 0);
      apb_write(REG_LEVEL_THRESHOLD, ($urandom() << SAMPLE_BITS) | thr_plan[p]);
      gap_max = gap_plan[p];
      run_phase(220);
    end

    drain();
    @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Result side: sample the handshake mid-cycle, check at the edge that takes the beat.
  initial begin : receiver
    bit            fire;
    bit            held_off;
    bit            rdy;
    int            hold_left;
    int            mode_left;
    int            pattern_step;
    ready_mode_e   mode;
    timer_report_t got;
    held_off     = 1'b0;
    hold_left    = 0;
    mode_left    = 0;
    pattern_step = 0;
    mode         = RDY_ALWAYS;
    forever begin
      @(negedge clk);
      fire              = out_valid && out_ready && !rst;
      got.sample_seen   = sample_seen;
      got.flags.active  = level_active;
      got.flags.rise    = rising_edge;
      got.flags.fall    = falling_edge;
      got.on_time_now   = on_time_now;
      got.off_time_now  = off_time_now;
      got.on_time_last  = on_time_last;
      got.off_time_last = off_time_last;
      got.on_periods    = on_periods;
      got.off_periods   = off_periods;
      @(posedge clk);
      if (fire) sb.check_report(got);
      // hold off once for a long stretch so the block backs up into its input
      if (!held_off && sb.noted >= HOLD_OFF_AFTER) begin
        held_off  = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_e'($urandom_range(3, 0));
          mode_left = $urandom_range(200, 20);
        end
        mode_left--;
        case (mode)
          RDY_ALWAYS: rdy = 1'b1;
          RDY_MOSTLY: rdy = $urandom_range(3, 0) != 0;
          RDY_COIN: rdy = $urandom_range(1, 0) != 0;
          default: begin
            rdy = (pattern_step % 5) < 3;
            pattern_step++;
          end
        endcase
      end
      out_ready <= rdy;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
